// File: rtl/core/polygon_perimeter_filter_macros.svh
// assertion helpers for polygon_perimeter_filter.sv
`ifndef POLYGON_PERIMETER_FILTER_MACROS_SVH
`define POLYGON_PERIMETER_FILTER_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define PPF_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ppf: implication check failed");

// next-cycle implication, checked on every rising edge outside reset
`define PPF_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ppf: next-cycle check failed");

`endif

// File: rtl/core/ppf_pkg.sv
package ppf_pkg;

   // fixed point format of the coordinates
   localparam int FRAC_BITS = 8;
   localparam int COORD_W   = 16;

   // edge length datapath widths
   localparam int MAG_W      = COORD_W;
   localparam int SQ_W       = 2 * MAG_W;
   localparam int RAD_W      = SQ_W + 2;
   localparam int ROOT_W     = RAD_W / 2;
   localparam int REM_W      = ROOT_W + 3;
   localparam int ROOT_STEPS = ROOT_W;
   localparam int STEP_W     = $clog2(ROOT_STEPS);

   // perimeter sum and vertex count
   localparam int SUM_W   = 32;
   localparam int COUNT_W = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
   localparam logic [SUM_W-1:0]   SUM_MAX      = '1;
   localparam logic [SUM_W-1:0]   THRESH_RESET = SUM_W'(4 << FRAC_BITS);

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SQX   = 5'b00010,
      ST_SQY   = 5'b00100,
      ST_ROOT  = 5'b01000,
      ST_ACCUM = 5'b10000
   } state_type;

endpackage

// File: rtl/core/ppf_req_if.sv
interface ppf_req_if import ppf_pkg::*; ();

   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] vertex_x;
   logic signed [COORD_W-1:0] vertex_y;
   logic                      last_vertex;

   modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                   input ready);
   modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                   output ready);

endinterface

// File: rtl/core/ppf_rsp_if.sv
interface ppf_rsp_if import ppf_pkg::*; ();

   logic               valid;
   logic               ready;
   logic [SUM_W-1:0]   perimeter;
   logic               passes;
   logic [COUNT_W-1:0] vertex_count;

   modport source (output valid, output perimeter, output passes, output vertex_count,
                   input ready);
   modport sink   (input valid, input perimeter, input passes, input vertex_count,
                   output ready);

endinterface

// File: rtl/core/polygon_perimeter_filter.sv
// channel   direction  handshake      payload
// req_ch    in         valid / ready  vertex_x, vertex_y (Q8.8 signed), last_vertex
// rsp_ch    out        valid / ready  perimeter (Q24.8), passes, vertex_count
// csr       in         csr_wr_en      csr_wr_data = perimeter_threshold
//
// A first vertex that opens a polygon is only stored, plus an accumulate step if it closes it.
// Any other vertex passes through the accept step, two squaring passes through
// the shared multiplier, the bit-serial square root and one accumulate step.
// A closing vertex runs the edge unit twice.
// Synchronous reset clears the sequencer, the vertex count and the result valid,
// and loads the reset threshold.
// A held result stalls the closing accumulate step, and req_ch with it.

`include "polygon_perimeter_filter_macros.svh"

module polygon_perimeter_filter import ppf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   ppf_req_if.sink          req_ch,
   ppf_rsp_if.source        rsp_ch,
   input  logic             csr_wr_en,
   input  logic [SUM_W-1:0] csr_wr_data
);

   state_type state_ff, state_in;

   logic [SUM_W-1:0]   thresh_ff, thresh_in;
   logic [COORD_W-1:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic [COORD_W-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [COORD_W-1:0] op_ax_ff, op_ax_in, op_ay_ff, op_ay_in;
   logic               last_ff, last_in;
   logic               closing_ff, closing_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [RAD_W-1:0]   rad_ff, rad_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0]  root_ff, root_in;
   logic [STEP_W-1:0]  step_ff, step_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]   rsp_perimeter_ff, rsp_perimeter_in;
   logic               rsp_passes_ff, rsp_passes_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   // shared squaring unit
   logic [COORD_W-1:0] sel_a, sel_b;
   logic [COORD_W:0]   diff;
   logic [MAG_W-1:0]   mag;
   logic [SQ_W-1:0]    sq;

   // square root step
   logic [REM_W+1:0]   rem_cat;
   logic [REM_W+1:0]   trial;
   logic               take;

   // saturating accumulate
   logic [SUM_W:0]     sum_wide;
   logic [SUM_W-1:0]   sum_sat;
   logic               rsp_free;

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.perimeter    = rsp_perimeter_ff;
   assign rsp_ch.passes       = rsp_passes_ff;
   assign rsp_ch.vertex_count = rsp_count_ff;

   // operand select and absolute difference, one axis per cycle
   always_comb begin
      sel_a = (state_ff == ST_SQY) ? op_ay_ff : op_ax_ff;
      sel_b = (state_ff == ST_SQY) ? prev_y_ff : prev_x_ff;
      diff  = {sel_a[COORD_W-1], sel_a} - {sel_b[COORD_W-1], sel_b};
      mag   = diff[COORD_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];
      sq    = SQ_W'(mag) * SQ_W'(mag);
   end

   // one result bit of the root per cycle
   always_comb begin
      rem_cat = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial   = (REM_W+2)'({root_ff, 2'b01});
      take    = (rem_cat >= trial);
   end

   always_comb begin
      sum_wide = {1'b0, sum_ff} + (SUM_W+1)'(root_ff);
      sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
      rsp_free = !rsp_valid_ff || rsp_ch.ready;
   end

   // sequencer and next-state values
   always_comb begin
      state_in         = state_ff;
      thresh_in        = thresh_ff;
      first_x_in       = first_x_ff;
      first_y_in       = first_y_ff;
      prev_x_in        = prev_x_ff;
      prev_y_in        = prev_y_ff;
      op_ax_in         = op_ax_ff;
      op_ay_in         = op_ay_ff;
      last_in          = last_ff;
      closing_in       = closing_ff;
      sum_in           = sum_ff;
      count_in         = count_ff;
      rad_in           = rad_ff;
      rem_in           = rem_ff;
      root_in          = root_ff;
      step_in          = step_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ch.ready;
      rsp_perimeter_in = rsp_perimeter_ff;
      rsp_passes_in    = rsp_passes_ff;
      rsp_count_in     = rsp_count_ff;

      if (csr_wr_en) begin
         thresh_in = csr_wr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               prev_x_in = req_ch.vertex_x;
               prev_y_in = req_ch.vertex_y;
               last_in   = req_ch.last_vertex;
               if (count_ff == '0) begin
                  // opening vertex, a lone vertex closes with a zero edge
                  first_x_in = req_ch.vertex_x;
                  first_y_in = req_ch.vertex_y;
                  sum_in     = '0;
                  count_in   = COUNT_W'(1);
                  root_in    = '0;
                  closing_in = 1'b1;
                  if (req_ch.last_vertex) begin
                     state_in = ST_ACCUM;
                  end
               end else begin
                  op_ax_in   = prev_x_ff;
                  op_ay_in   = prev_y_ff;
                  closing_in = 1'b0;
                  if (count_ff != COUNT_MAX) begin
                     count_in = count_ff + 1'b1;
                  end
                  state_in = ST_SQX;
               end
            end
         end
         ST_SQX: begin
            rad_in   = RAD_W'(sq);
            state_in = ST_SQY;
         end
         ST_SQY: begin
            rad_in   = rad_ff + RAD_W'(sq);
            rem_in   = '0;
            root_in  = '0;
            step_in  = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            rad_in  = rad_ff << 2;
            root_in = {root_ff[ROOT_W-2:0], take};
            rem_in  = take ? REM_W'(rem_cat - trial) : REM_W'(rem_cat);
            step_in = STEP_W'(step_ff + 1'b1);
            if (step_ff == STEP_W'(ROOT_STEPS - 1)) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            if (!closing_ff) begin
               sum_in = sum_sat;
               if (last_ff) begin
                  // closing edge from this vertex back to the first
                  closing_in = 1'b1;
                  op_ax_in   = first_x_ff;
                  op_ay_in   = first_y_ff;
                  state_in   = ST_SQX;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (rsp_free) begin
               rsp_valid_in     = 1'b1;
               rsp_perimeter_in = sum_sat;
               rsp_passes_in    = (sum_sat > thresh_ff);
               rsp_count_in     = count_ff;
               sum_in           = '0;
               count_in         = '0;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thresh_ff    <= THRESH_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thresh_ff    <= thresh_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      first_x_ff       <= first_x_in;
      first_y_ff       <= first_y_in;
      prev_x_ff        <= prev_x_in;
      prev_y_ff        <= prev_y_in;
      op_ax_ff         <= op_ax_in;
      op_ay_ff         <= op_ay_in;
      last_ff          <= last_in;
      closing_ff       <= closing_in;
      sum_ff           <= sum_in;
      rad_ff           <= rad_in;
      rem_ff           <= rem_in;
      root_ff          <= root_in;
      step_ff          <= step_in;
      rsp_perimeter_ff <= rsp_perimeter_in;
      rsp_passes_ff    <= rsp_passes_in;
      rsp_count_ff     <= rsp_count_in;
   end

   // a vertex that continues an open polygon starts the squaring pass
   `PPF_ASSERT_NEXT(a_open_edge_starts, clock, reset, req_ch.valid && req_ch.ready && (count_ff != '0), state_ff == ST_SQX)

   // a new result only comes out of the closing accumulate step
   `PPF_ASSERT_IMPLY(a_rsp_from_accum, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_ACCUM)

   // an accumulate step always has an open polygon behind it
   `PPF_ASSERT_IMPLY(a_accum_has_count, clock, reset, state_ff == ST_ACCUM, count_ff != '0)

endmodule
